// ===== rtl/eesa_pkg.sv =====
// shared constants, types and saturating arithmetic for the stiffness assembly block
// no dependencies
`timescale 1ns / 1ps

package eesa_pkg;

    localparam int DIMS   = 3;
    localparam int NODES  = 8;
    localparam int POINTS = 12;

    localparam int NDOF      = NODES * DIMS;
    localparam int MAT_DEPTH = NDOF * NDOF;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int RES_AW    = $clog2(NDOF);
    localparam int NODE_W    = $clog2(NODES);
    localparam int PT_W      = $clog2(POINTS);
    localparam int DIM_W     = $clog2(DIMS);
    localparam int SHP_DEPTH = POINTS * NODES;
    localparam int SHP_AW    = $clog2(SHP_DEPTH);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_NODE,
        CMD_POINT,
        CMD_SHAPE,
        CMD_GRAD,
        CMD_ASSEMBLE,
        CMD_RD_MAT,
        CMD_RD_RES
    } cmd_t;

    typedef logic signed [31:0] q_t;
    typedef logic [DIMS-1:0][31:0] vec_t;

    typedef struct packed {
        logic sat;
        q_t   val;
    } qres_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = -32'sh7FFF_FFFF - 32'sh1;

    // saturating a + b, or a - b when sub is set
    function automatic qres_t q_add(input q_t a, input q_t b, input logic sub);
        logic signed [32:0] s;
        qres_t r;
        s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] != s[31])
        begin
            r.sat = 1'b1;
            r.val = s[32] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = s[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/eesa_qmul.sv =====
// registered Q16.16 multiplier: full product registered, then floor shift and clamp
// depends on eesa_pkg
`timescale 1ns / 1ps

module eesa_qmul
(
    input  logic            clk,
    input  eesa_pkg::q_t    a,
    input  eesa_pkg::q_t    b,
    output eesa_pkg::qres_t res
);
    import eesa_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_comb
    begin
        // arithmetic shift rounds toward minus infinity
        shifted = prod_reg >>> 16;
        if ((&shifted[63:31]) || !(|shifted[63:31]))
        begin
            res.sat = 1'b0;
            res.val = shifted[31:0];
        end
        else
        begin
            res.sat = 1'b1;
            res.val = shifted[63] ? Q_MIN : Q_MAX;
        end
    end

endmodule

// ===== rtl/elastic_element_stiffness_assembly.sv =====
// element stiffness assembly for linear elasticity, Q16.16, sequencer around memories
// depends on eesa_pkg and eesa_qmul
//
// channel | dir | tdata                                      | tuser
// s_*     | in  | point,node,left,right,row,column,a,b,x,y,z | command
// m_*     | out | read_value                                 | status
//
// a clear writes all NDOF*NDOF (576) matrix words through the matrix port
// assemble is paced by the one multiplier and the read-modify-write of the single matrix port
// after reset a clearing pass zeroes matrix and residual, no item taken
// a finished result waits in a holding register while the output is stalled
`timescale 1ns / 1ps

module elastic_element_stiffness_assembly
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_index[3:0] node_index[6:4] left_node[9:7] right_node[12:10] row[17:13]
    // column[22:18] scalar_a[54:23] scalar_b[86:55] comp_x[118:87] comp_y[150:119]
    // comp_z[182:151] zero[183]
    input  logic [183:0] s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_value[31:0]
    output logic [31:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);
    import eesa_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_R_MAT, S_R_RES,
        S_A_PT, S_A_SHP, S_A_MU, S_A_LAM, S_A_NEG, S_A_GRD, S_A_GLD,
        S_T_M1, S_T_M2, S_T_M3,
        S_P_FD, S_P_ML, S_P_MRR, S_P_MR, S_P_RL, S_P_RRR, S_P_RR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {PH_DIAG, PH_OFF, PH_LAM, PH_FINAL} phase_t;

    // input fields
    logic [3:0] pi_in;
    logic [2:0] ni_in, ln_in, rn_in;
    logic [4:0] row_in, col_in;
    q_t         sa_in, sb_in;
    vec_t       comp_in;
    cmd_t       cmd_in;

    assign pi_in  = s_tdata[3:0];
    assign ni_in  = s_tdata[6:4];
    assign ln_in  = s_tdata[9:7];
    assign rn_in  = s_tdata[12:10];
    assign row_in = s_tdata[17:13];
    assign col_in = s_tdata[22:18];
    assign sa_in  = s_tdata[54:23];
    assign sb_in  = s_tdata[86:55];
    assign cmd_in = cmd_t'(s_tuser);

    always_comb
    begin
        for (int k = 0; k < DIMS; k++)
        begin
            comp_in[k] = (k == 0) ? s_tdata[118:87] :
                         (k == 1) ? s_tdata[150:119] : s_tdata[182:151];
        end
    end

    // small stores, each read at one place
    q_t              mu_node [NODES];
    q_t              lam_node[NODES];
    vec_t            disp_node[NODES];
    vec_t            area_pt [POINTS];
    logic [NODE_W-1:0] left_pt [POINTS];
    logic [NODE_W-1:0] right_pt[POINTS];

    // memories
    q_t   shp_mem[SHP_DEPTH];
    vec_t grd_mem[SHP_DEPTH];
    q_t   mat_mem[MAT_DEPTH];
    q_t   res_mem[NDOF];

    q_t   shp_rdata_reg;
    vec_t grd_rdata_reg;
    q_t   mat_rdata_reg;
    q_t   res_rdata_reg;

    state_t state_reg;
    phase_t phase_reg;
    logic [MAT_AW-1:0] clr_cnt_reg;
    logic              clr_report_reg;
    logic [PT_W-1:0]   ip_reg;
    logic [NODE_W-1:0] ic_reg;
    logic [DIM_W-1:0]  i_reg, j_reg, l_reg, colk_reg;
    logic [NODE_W-1:0] il_reg, ir_reg;
    q_t   mu_reg, lam_reg, nmu_reg, nlam_reg, diag_reg, r_reg, fac_reg, fd_reg;
    vec_t g_reg, d_reg, a_reg;
    logic sat_reg;

    logic res_valid_reg;
    q_t   res_value_reg;
    logic [1:0] res_status_reg;
    logic out_valid_reg;
    q_t   out_value_reg;
    logic [1:0] out_status_reg;

    logic accept;
    logic pt_ok, node_ok, shp_ok, rdm_ok, rdr_ok;

    assign s_tready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    assign pt_ok   = (pi_in < POINTS) && (ln_in < NODES) && (rn_in < NODES);
    assign node_ok = (ni_in < NODES);
    assign shp_ok  = (pi_in < POINTS) && (ni_in < NODES);
    assign rdm_ok  = (row_in < NDOF) && (col_in < NDOF);
    assign rdr_ok  = (row_in < NDOF);

    // multiplier
    q_t    mul_a, mul_b;
    qres_t mul_res;

    eesa_qmul u_qmul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    logic [RES_AW-1:0] lrow, rrow, colv;
    logic [MAT_AW-1:0] mat_laddr, mat_raddr_r, mat_raddr, mat_waddr;
    logic [RES_AW-1:0] res_raddr, res_waddr;
    logic [SHP_AW-1:0] shp_raddr, grd_raddr, ld_addr;
    logic [DIM_W-1:0]  ksel;
    logic mat_we, res_we, shp_we, grd_we;
    q_t   mat_wdata, res_wdata, acc_a;
    qres_t mat_sum, res_sum, acc_sum, neg_mu, neg_lam;
    logic [NODE_W-1:0] ic_nxt;

    always_comb
    begin
        lrow = RES_AW'(il_reg) * RES_AW'(DIMS) + RES_AW'(i_reg);
        rrow = RES_AW'(ir_reg) * RES_AW'(DIMS) + RES_AW'(i_reg);
        colv = RES_AW'(ic_reg) * RES_AW'(DIMS) + RES_AW'(colk_reg);
        mat_laddr   = MAT_AW'(lrow) * MAT_AW'(NDOF) + MAT_AW'(colv);
        mat_raddr_r = MAT_AW'(rrow) * MAT_AW'(NDOF) + MAT_AW'(colv);

        unique case (state_reg)
            S_P_FD:  mat_raddr = mat_laddr;
            S_P_MRR: mat_raddr = mat_raddr_r;
            default: mat_raddr = rdm_ok ? MAT_AW'(row_in) * MAT_AW'(NDOF) + MAT_AW'(col_in)
                                        : '0;
        endcase

        unique case (state_reg)
            S_P_MR:  res_raddr = lrow;
            S_P_RRR: res_raddr = rrow;
            default: res_raddr = rdr_ok ? row_in[RES_AW-1:0] : '0;
        endcase

        mat_sum = q_add(mat_rdata_reg, fac_reg, state_reg == S_P_MR);
        res_sum = q_add(res_rdata_reg, fd_reg, state_reg == S_P_RL);

        mat_we    = (state_reg == S_CLR) || (state_reg == S_P_ML) || (state_reg == S_P_MR);
        mat_waddr = (state_reg == S_CLR) ? clr_cnt_reg :
                    (state_reg == S_P_ML) ? mat_laddr : mat_raddr_r;
        mat_wdata = (state_reg == S_CLR) ? '0 : mat_sum.val;

        res_we    = ((state_reg == S_CLR) && (clr_cnt_reg < MAT_AW'(NDOF))) ||
                    (state_reg == S_P_RL) || (state_reg == S_P_RR);
        res_waddr = (state_reg == S_CLR) ? clr_cnt_reg[RES_AW-1:0] :
                    (state_reg == S_P_RL) ? lrow : rrow;
        res_wdata = (state_reg == S_CLR) ? '0 : res_sum.val;

        ic_nxt    = (ic_reg == NODE_W'(NODES - 1)) ? '0 : ic_reg + 1'b1;
        shp_raddr = SHP_AW'(ip_reg) * SHP_AW'(NODES) +
                    ((state_reg == S_A_LAM) ? SHP_AW'(ic_nxt) : '0);
        grd_raddr = SHP_AW'(ip_reg) * SHP_AW'(NODES) + SHP_AW'(ic_reg);
        ld_addr   = SHP_AW'(pi_in[PT_W-1:0]) * SHP_AW'(NODES) + SHP_AW'(ni_in[NODE_W-1:0]);
        shp_we    = accept && (cmd_in == CMD_SHAPE) && shp_ok;
        grd_we    = accept && (cmd_in == CMD_GRAD) && shp_ok;

        unique case (phase_reg)
            PH_DIAG: ksel = j_reg;
            PH_OFF:  ksel = i_reg;
            default: ksel = l_reg;
        endcase

        unique case (state_reg)
            S_A_SHP:
            begin
                mul_a = shp_rdata_reg;
                mul_b = mu_node[ic_reg];
            end
            S_A_MU:
            begin
                mul_a = r_reg;
                mul_b = lam_node[ic_reg];
            end
            S_T_M1:
            begin
                mul_a = (phase_reg == PH_LAM) ? nlam_reg : nmu_reg;
                mul_b = g_reg[ksel];
            end
            S_T_M2:
            begin
                mul_a = mul_res.val;
                mul_b = a_reg[j_reg];
            end
            S_P_FD:
            begin
                mul_a = fac_reg;
                mul_b = d_reg[colk_reg];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        unique case (state_reg)
            S_A_MU:  acc_a = mu_reg;
            S_A_LAM: acc_a = lam_reg;
            default: acc_a = diag_reg;
        endcase
        acc_sum = q_add(acc_a, mul_res.val, 1'b0);
        neg_mu  = q_add('0, mu_reg, 1'b1);
        neg_lam = q_add('0, lam_reg, 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        mat_rdata_reg <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_rdata_reg <= res_mem[res_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (shp_we)
        begin
            shp_mem[ld_addr] <= sa_in;
        end
        shp_rdata_reg <= shp_mem[shp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (grd_we)
        begin
            grd_mem[ld_addr] <= comp_in;
        end
        grd_rdata_reg <= grd_mem[grd_raddr];
    end

    // per-node and per-point registers
    always_ff @(posedge clk)
    begin
        if (accept && (cmd_in == CMD_NODE) && node_ok)
        begin
            mu_node[ni_in[NODE_W-1:0]]   <= sa_in;
            lam_node[ni_in[NODE_W-1:0]]  <= sb_in;
            disp_node[ni_in[NODE_W-1:0]] <= comp_in;
        end
        if (accept && (cmd_in == CMD_POINT) && pt_ok)
        begin
            area_pt[pi_in[PT_W-1:0]]  <= comp_in;
            left_pt[pi_in[PT_W-1:0]]  <= ln_in[NODE_W-1:0];
            right_pt[pi_in[PT_W-1:0]] <= rn_in[NODE_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            phase_reg      <= PH_DIAG;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            sat_reg        <= 1'b0;
            ip_reg         <= '0;
            ic_reg         <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            l_reg          <= '0;
            colk_reg       <= '0;
        end
        else
        begin
            // output stage
            if (res_valid_reg && (!out_valid_reg || m_tready))
            begin
                out_valid_reg  <= 1'b1;
                out_value_reg  <= res_value_reg;
                out_status_reg <= res_status_reg;
                res_valid_reg  <= 1'b0;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == MAT_AW'(MAT_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                        if (clr_report_reg)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_value_reg  <= '0;
                            res_status_reg <= ST_OK;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_value_reg <= '0;
                        unique case (cmd_in)
                            CMD_CLEAR:
                            begin
                                clr_cnt_reg    <= '0;
                                clr_report_reg <= 1'b1;
                                state_reg      <= S_CLR;
                            end
                            CMD_NODE:
                            begin
                                res_valid_reg  <= 1'b1;
                                res_status_reg <= node_ok ? ST_OK : ST_RANGE;
                            end
                            CMD_POINT:
                            begin
                                res_valid_reg  <= 1'b1;
                                res_status_reg <= pt_ok ? ST_OK : ST_RANGE;
                            end
                            CMD_SHAPE, CMD_GRAD:
                            begin
                                res_valid_reg  <= 1'b1;
                                res_status_reg <= shp_ok ? ST_OK : ST_RANGE;
                            end
                            CMD_ASSEMBLE:
                            begin
                                ip_reg    <= '0;
                                sat_reg   <= 1'b0;
                                state_reg <= S_A_PT;
                            end
                            CMD_RD_MAT:
                            begin
                                if (rdm_ok)
                                begin
                                    state_reg <= S_R_MAT;
                                end
                                else
                                begin
                                    res_valid_reg  <= 1'b1;
                                    res_status_reg <= ST_RANGE;
                                end
                            end
                            default:
                            begin
                                if (rdr_ok)
                                begin
                                    state_reg <= S_R_RES;
                                end
                                else
                                begin
                                    res_valid_reg  <= 1'b1;
                                    res_status_reg <= ST_RANGE;
                                end
                            end
                        endcase
                    end
                end
                S_R_MAT:
                begin
                    res_valid_reg  <= 1'b1;
                    res_value_reg  <= mat_rdata_reg;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_IDLE;
                end
                S_R_RES:
                begin
                    res_valid_reg  <= 1'b1;
                    res_value_reg  <= res_rdata_reg;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_IDLE;
                end
                S_A_PT:
                begin
                    il_reg    <= left_pt[ip_reg];
                    ir_reg    <= right_pt[ip_reg];
                    a_reg     <= area_pt[ip_reg];
                    mu_reg    <= '0;
                    lam_reg   <= '0;
                    ic_reg    <= '0;
                    state_reg <= S_A_SHP;
                end
                S_A_SHP:
                begin
                    r_reg     <= shp_rdata_reg;
                    state_reg <= S_A_MU;
                end
                S_A_MU:
                begin
                    mu_reg    <= acc_sum.val;
                    sat_reg   <= sat_reg | acc_sum.sat | mul_res.sat;
                    state_reg <= S_A_LAM;
                end
                S_A_LAM:
                begin
                    lam_reg <= acc_sum.val;
                    sat_reg <= sat_reg | acc_sum.sat | mul_res.sat;
                    if (ic_reg == NODE_W'(NODES - 1))
                    begin
                        state_reg <= S_A_NEG;
                    end
                    else
                    begin
                        ic_reg    <= ic_nxt;
                        state_reg <= S_A_SHP;
                    end
                end
                S_A_NEG:
                begin
                    nmu_reg   <= neg_mu.val;
                    nlam_reg  <= neg_lam.val;
                    sat_reg   <= sat_reg | neg_mu.sat | neg_lam.sat;
                    ic_reg    <= '0;
                    state_reg <= S_A_GRD;
                end
                S_A_GRD:
                begin
                    state_reg <= S_A_GLD;
                end
                S_A_GLD:
                begin
                    g_reg     <= grd_rdata_reg;
                    d_reg     <= disp_node[ic_reg];
                    i_reg     <= '0;
                    j_reg     <= '0;
                    diag_reg  <= '0;
                    phase_reg <= PH_DIAG;
                    state_reg <= S_T_M1;
                end
                S_T_M1:
                begin
                    state_reg <= S_T_M2;
                end
                S_T_M2:
                begin
                    sat_reg   <= sat_reg | mul_res.sat;
                    state_reg <= S_T_M3;
                end
                S_T_M3:
                begin
                    if (phase_reg == PH_DIAG)
                    begin
                        diag_reg  <= acc_sum.val;
                        sat_reg   <= sat_reg | mul_res.sat | acc_sum.sat;
                        phase_reg <= PH_OFF;
                        state_reg <= S_T_M1;
                    end
                    else
                    begin
                        fac_reg   <= mul_res.val;
                        sat_reg   <= sat_reg | mul_res.sat;
                        colk_reg  <= (phase_reg == PH_OFF) ? j_reg : l_reg;
                        state_reg <= S_P_FD;
                    end
                end
                S_P_FD:
                begin
                    state_reg <= S_P_ML;
                end
                S_P_ML:
                begin
                    fd_reg    <= mul_res.val;
                    sat_reg   <= sat_reg | mul_res.sat | mat_sum.sat;
                    state_reg <= S_P_MRR;
                end
                S_P_MRR:
                begin
                    state_reg <= S_P_MR;
                end
                S_P_MR:
                begin
                    sat_reg   <= sat_reg | mat_sum.sat;
                    state_reg <= S_P_RL;
                end
                S_P_RL:
                begin
                    sat_reg   <= sat_reg | res_sum.sat;
                    state_reg <= S_P_RRR;
                end
                S_P_RRR:
                begin
                    state_reg <= S_P_RR;
                end
                S_P_RR:
                begin
                    sat_reg <= sat_reg | res_sum.sat;
                    // pick the next term by where this pair came from
                    if ((phase_reg == PH_OFF) && (i_reg == j_reg))
                    begin
                        phase_reg <= PH_LAM;
                        l_reg     <= '0;
                        state_reg <= S_T_M1;
                    end
                    else if ((phase_reg == PH_LAM) && (l_reg != DIM_W'(DIMS - 1)))
                    begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_T_M1;
                    end
                    else if (phase_reg != PH_FINAL)
                    begin
                        if (j_reg != DIM_W'(DIMS - 1))
                        begin
                            j_reg     <= j_reg + 1'b1;
                            phase_reg <= PH_DIAG;
                            state_reg <= S_T_M1;
                        end
                        else
                        begin
                            phase_reg <= PH_FINAL;
                            fac_reg   <= diag_reg;
                            colk_reg  <= i_reg;
                            state_reg <= S_P_FD;
                        end
                    end
                    else if (i_reg != DIM_W'(DIMS - 1))
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= '0;
                        diag_reg  <= '0;
                        phase_reg <= PH_DIAG;
                        state_reg <= S_T_M1;
                    end
                    else if (ic_reg != NODE_W'(NODES - 1))
                    begin
                        ic_reg    <= ic_reg + 1'b1;
                        state_reg <= S_A_GRD;
                    end
                    else if (ip_reg != PT_W'(POINTS - 1))
                    begin
                        ip_reg    <= ip_reg + 1'b1;
                        state_reg <= S_A_PT;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    res_valid_reg  <= 1'b1;
                    res_value_reg  <= '0;
                    res_status_reg <= sat_reg ? ST_SAT : ST_OK;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/eesa_checker.sv =====
// port-level checks for the stiffness assembly block, bound to the top level
// depends on eesa_pkg
`timescale 1ns / 1ps

module eesa_port_checks
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import eesa_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // out-of-range reads report a zero value
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_RANGE) |-> (m_tdata == 32'd0))
        else $error("range error with nonzero value");

    // no item is taken as the clearing pass after reset begins
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |=> !s_tready)
        else $error("item taken during reset clear");

    // no result appears as the reset clearing pass begins
    a_no_out_in_clear: assert property (@(posedge clk)
        $rose(rst_n) |=> !m_tvalid)
        else $error("result during reset clear");

endmodule

bind elastic_element_stiffness_assembly eesa_port_checks u_eesa_port_checks (.*);

// ===== verif/eesa_checker.sv =====
// checker for the stiffness assembly block: watches both channels, predicts every result
// and compares it with what comes out; depends on eesa_pkg
`timescale 1ns / 1ps

module eesa_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [183:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending
);
    import eesa_pkg::*;

    typedef struct {
        q_t         value;
        logic [1:0] status;
    } reply_t;

    reply_t replies_due[$];

    q_t         disp  [NDOF];
    q_t         mu    [NODES];
    q_t         lam   [NODES];
    q_t         area  [POINTS*DIMS];
    int         lnode [POINTS];
    int         rnode [POINTS];
    q_t         shp   [POINTS*NODES];
    q_t         grd   [POINTS*NODES*DIMS];
    q_t         kmat  [NDOF*NDOF];
    q_t         rvec  [NDOF];
    bit         sat_seen;

    function automatic q_t clip(input longint v);
        if (v > longint'(Q_MAX))
        begin
            sat_seen = 1'b1;
            return Q_MAX;
        end
        if (v < longint'(Q_MIN))
        begin
            sat_seen = 1'b1;
            return Q_MIN;
        end
        return q_t'(v);
    endfunction

    // arithmetic shift of the full product rounds toward minus infinity
    function automatic q_t fmul(input q_t a, input q_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip(p >>> 16);
    endfunction

    function automatic q_t fadd(input q_t a, input q_t b);
        return clip(longint'(a) + longint'(b));
    endfunction

    function automatic q_t fsub(input q_t a, input q_t b);
        return clip(longint'(a) - longint'(b));
    endfunction

    task automatic scatter(input int lrow, input int rrow, input int col, input q_t fac,
                           input q_t d);
        q_t fd;
        fd = fmul(fac, d);
        kmat[lrow*NDOF+col] = fadd(kmat[lrow*NDOF+col], fac);
        kmat[rrow*NDOF+col] = fsub(kmat[rrow*NDOF+col], fac);
        rvec[lrow] = fsub(rvec[lrow], fd);
        rvec[rrow] = fadd(rvec[rrow], fd);
    endtask

    task automatic assemble_element();
        int il, ir, gb, lrow, rrow;
        q_t mu_ip, lam_ip, nmu, nlam, diag, ax;
        for (int ip = 0; ip < POINTS; ip++)
        begin
            il = lnode[ip];
            ir = rnode[ip];
            mu_ip = 0;
            lam_ip = 0;
            for (int ic = 0; ic < NODES; ic++)
            begin
                mu_ip = fadd(mu_ip, fmul(shp[ip*NODES+ic], mu[ic]));
                lam_ip = fadd(lam_ip, fmul(shp[ip*NODES+ic], lam[ic]));
            end
            nmu = clip(-longint'(mu_ip));
            nlam = clip(-longint'(lam_ip));
            for (int ic = 0; ic < NODES; ic++)
            begin
                gb = (ip*NODES + ic) * DIMS;
                for (int i = 0; i < DIMS; i++)
                begin
                    lrow = il*DIMS + i;
                    rrow = ir*DIMS + i;
                    diag = 0;
                    for (int j = 0; j < DIMS; j++)
                    begin
                        ax = area[ip*DIMS+j];
                        diag = fadd(diag, fmul(fmul(nmu, grd[gb+j]), ax));
                        scatter(lrow, rrow, ic*DIMS+j, fmul(fmul(nmu, grd[gb+i]), ax),
                                disp[ic*DIMS+j]);
                        if (i == j)
                        begin
                            for (int l = 0; l < DIMS; l++)
                                scatter(lrow, rrow, ic*DIMS+l,
                                        fmul(fmul(nlam, grd[gb+l]), ax), disp[ic*DIMS+l]);
                        end
                    end
                    scatter(lrow, rrow, ic*DIMS+i, diag, disp[ic*DIMS+i]);
                end
            end
        end
    endtask

    task automatic predict(input cmd_t cmd, input logic [183:0] d);
        int pt, nd, lf, rt, row, col;
        q_t sa, sb;
        q_t comp [3];
        reply_t rep;
        pt = d[3:0];
        nd = d[6:4];
        lf = d[9:7];
        rt = d[12:10];
        row = d[17:13];
        col = d[22:18];
        sa = d[54:23];
        sb = d[86:55];
        comp[0] = d[118:87];
        comp[1] = d[150:119];
        comp[2] = d[182:151];
        rep.value = 0;
        rep.status = ST_OK;
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (kmat[k]) kmat[k] = 0;
                foreach (rvec[k]) rvec[k] = 0;
            end
            CMD_NODE:
                if (nd >= NODES) rep.status = ST_RANGE;
                else
                begin
                    mu[nd] = sa;
                    lam[nd] = sb;
                    for (int j = 0; j < DIMS; j++) disp[nd*DIMS+j] = comp[j];
                end
            CMD_POINT:
                if (pt >= POINTS || lf >= NODES || rt >= NODES) rep.status = ST_RANGE;
                else
                begin
                    lnode[pt] = lf;
                    rnode[pt] = rt;
                    for (int j = 0; j < DIMS; j++) area[pt*DIMS+j] = comp[j];
                end
            CMD_SHAPE:
                if (pt >= POINTS || nd >= NODES) rep.status = ST_RANGE;
                else shp[pt*NODES+nd] = sa;
            CMD_GRAD:
                if (pt >= POINTS || nd >= NODES) rep.status = ST_RANGE;
                else
                    for (int j = 0; j < DIMS; j++) grd[(pt*NODES+nd)*DIMS+j] = comp[j];
            CMD_ASSEMBLE:
            begin
                sat_seen = 1'b0;
                assemble_element();
                if (sat_seen) rep.status = ST_SAT;
            end
            CMD_RD_MAT:
                if (row >= NDOF || col >= NDOF) rep.status = ST_RANGE;
                else rep.value = kmat[row*NDOF+col];
            default:
                if (row >= NDOF) rep.status = ST_RANGE;
                else rep.value = rvec[row];
        endcase
        replies_due.push_back(rep);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (disp[k]) disp[k] = 0;
            foreach (mu[k]) mu[k] = 0;
            foreach (lam[k]) lam[k] = 0;
            foreach (area[k]) area[k] = 0;
            foreach (lnode[k]) lnode[k] = 0;
            foreach (rnode[k]) rnode[k] = 0;
            foreach (shp[k]) shp[k] = 0;
            foreach (grd[k]) grd[k] = 0;
            foreach (kmat[k]) kmat[k] = 0;
            foreach (rvec[k]) rvec[k] = 0;
            replies_due.delete();
            errors = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    errors++;
                    $display("%t: unexpected item value %h status %0d", $time, m_tdata,
                             m_tuser);
                end
                else
                begin
                    reply_t want;
                    want = replies_due.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        errors++;
                        $display("%t: read_value expected %h actual %h", $time, want.value,
                                 m_tdata);
                    end
                    if (m_tuser !== want.status)
                    begin
                        errors++;
                        $display("%t: status expected %0d actual %0d", $time, want.status,
                                 m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict(cmd_t'(s_tuser), s_tdata);
        end
        pending = replies_due.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
    end

endmodule

// ===== verif/elastic_element_stiffness_assembly_tb.sv =====
// testbench top for the stiffness assembly block: clock, reset, stimulus and verdict
// depends on eesa_pkg, eesa_checker and the block itself
`timescale 1ns / 1ps

module elastic_element_stiffness_assembly_tb;
    import eesa_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;

    bit           calm;
    int           hold_start;
    int           hold_cnt;

    elastic_element_stiffness_assembly DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    eesa_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, with a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_start > 0)
            begin
                hold_cnt = hold_start;
                hold_start = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 29);
        end
    end

    function automatic q_t any32();
        return q_t'($urandom);
    endfunction

    // mostly within +/- range units in Q16.16, now and then anything
    function automatic q_t modest(input int range);
        if ($urandom_range(99) < 3) return any32();
        return q_t'($signed($urandom_range(2*range*65536)) - range*65536);
    endfunction

    task automatic send(input cmd_t cmd, input logic [3:0] pt, input logic [2:0] nd,
                        input logic [2:0] lf, input logic [2:0] rt, input logic [4:0] row,
                        input logic [4:0] col, input q_t a, input q_t b, input q_t x,
                        input q_t y, input q_t z);
        while (!calm && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, z, y, x, b, a, col, row, rt, lf, nd, pt};
        do @(posedge clk); while (!s_tready);
    endtask

    // command with every field random, then the caller's choice of indexes
    task automatic send_noise(input cmd_t cmd, input logic [3:0] pt, input logic [2:0] nd,
                              input logic [4:0] row, input logic [4:0] col);
        send(cmd, pt, nd, 3'($urandom), 3'($urandom), row, col, any32(), any32(), any32(),
             any32(), any32());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic load_node(input int n);
        send(CMD_NODE, 4'($urandom), 3'(n), 3'($urandom), 3'($urandom), 5'($urandom),
             5'($urandom), modest(2), modest(2), modest(1), modest(1), modest(1));
    endtask

    task automatic load_point(input int p);
        logic [2:0] l;
        l = 3'($urandom);
        send(CMD_POINT, 4'(p), 3'($urandom), l, ($urandom_range(3) == 0) ? l : 3'($urandom),
             5'($urandom), 5'($urandom), any32(), any32(), modest(1), modest(1), modest(1));
    endtask

    task automatic load_shape(input int p, input int n);
        send(CMD_SHAPE, 4'(p), 3'(n), 3'($urandom), 3'($urandom), 5'($urandom),
             5'($urandom), modest(1), any32(), any32(), any32(), any32());
    endtask

    task automatic load_grad(input int p, input int n);
        send(CMD_GRAD, 4'(p), 3'(n), 3'($urandom), 3'($urandom), 5'($urandom),
             5'($urandom), any32(), any32(), modest(1), modest(1), modest(1));
    endtask

    task automatic read_random();
        logic [4:0] row;
        logic [4:0] col;
        row = ($urandom_range(99) < 85) ? 5'($urandom_range(NDOF-1)) : 5'($urandom);
        col = ($urandom_range(99) < 85) ? 5'($urandom_range(NDOF-1)) : 5'($urandom);
        send_noise(($urandom_range(1) != 0) ? CMD_RD_MAT : CMD_RD_RES, 4'($urandom),
                   3'($urandom), row, col);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_CLEAR;
        calm = 1'b0;
        hold_start = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // matrix and residual read as zero after reset, out-of-range reads and loads
        send_noise(CMD_RD_MAT, 0, 0, 0, 0);
        send_noise(CMD_RD_MAT, 0, 0, 5'(NDOF-1), 5'(NDOF-1));
        send_noise(CMD_RD_RES, 0, 0, 5'(NDOF-1), 0);
        send_noise(CMD_RD_MAT, 0, 0, 5'(NDOF), 0);
        send_noise(CMD_RD_MAT, 0, 0, 0, 5'h1f);
        send_noise(CMD_RD_RES, 0, 0, 5'h1f, 0);
        send(CMD_POINT, 4'(POINTS), 0, 0, 7, 0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0);
        send(CMD_SHAPE, 4'hf, 7, 0, 0, 0, 0, Q_MIN, 0, 0, 0, 0);
        send(CMD_GRAD, 4'(POINTS), 3, 0, 0, 0, 0, 0, 0, Q_MIN, Q_MAX, -1);
        send_noise(CMD_CLEAR, 0, 0, 0, 0);
        wait_drained();

        // full element, then assemble and a burst of reads behind a long hold-off
        for (int n = 0; n < NODES; n++) load_node(n);
        for (int p = 0; p < POINTS; p++) load_point(p);
        for (int p = 0; p < POINTS; p++)
            for (int n = 0; n < NODES; n++)
            begin
                load_shape(p, n);
                load_grad(p, n);
            end
        send_noise(CMD_ASSEMBLE, 0, 0, 0, 0);
        wait_drained();
        hold_start = 400;
        for (int k = 0; k < 60; k++) read_random();
        wait_drained();

        // extreme mu on every node so assemble saturates
        for (int n = 0; n < NODES; n++)
            send(CMD_NODE, 0, 3'(n), 0, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send(CMD_SHAPE, 0, 0, 0, 0, 0, 0, Q_MAX, 0, 0, 0, 0);
        send_noise(CMD_ASSEMBLE, 0, 0, 0, 0);
        send_noise(CMD_RD_RES, 0, 0, 0, 0);
        send_noise(CMD_RD_MAT, 0, 0, 0, 0);
        send_noise(CMD_CLEAR, 0, 0, 0, 0);
        wait_drained();
        for (int n = 0; n < NODES; n++) load_node(n);

        // random rounds: loads, an assemble, reads
        for (int round = 0; round < 5; round++)
        begin
            calm = (round == 2);
            for (int k = 0; k < 80; k++)
            begin
                case ($urandom_range(9))
                    0, 1:    load_node($urandom_range(NODES-1));
                    2:       load_point($urandom_range(POINTS-1));
                    3, 4:    load_shape($urandom_range(POINTS-1), $urandom_range(NODES-1));
                    5, 6:    load_grad($urandom_range(POINTS-1), $urandom_range(NODES-1));
                    7:       send_noise(cmd_t'($urandom_range(CMD_POINT, CMD_GRAD)),
                                        4'($urandom_range(POINTS, 15)), 3'($urandom),
                                        5'($urandom), 5'($urandom));
                    8:       read_random();
                    default: if ($urandom_range(3) == 0) send_noise(CMD_CLEAR, 0, 0, 0, 0);
                             else read_random();
                endcase
            end
            send_noise(CMD_ASSEMBLE, 4'($urandom), 3'($urandom), 5'($urandom),
                       5'($urandom));
            for (int k = 0; k < 80; k++) read_random();
            if (round % 2 == 1) wait_drained();
        end
        calm = 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
